>>> src/leb_pkg.sv
// ============================================================================
// leb_pkg - shared types and constants for the LEB128 encoder
// Command codes, job kinds and the job record passed from front to back.
// ============================================================================
package leb_pkg;

    // Input command codes (tuser)
    typedef enum logic [1:0] {
        CMD_U32_MIN   = 2'd0,
        CMD_U32_FIXED = 2'd1,
        CMD_S32       = 2'd2,
        CMD_S64       = 2'd3
    } cmd_t;

    // How the back end walks the operand
    typedef enum logic [1:0] {
        KIND_UNSIGNED = 2'd0,
        KIND_FIXED    = 2'd1,
        KIND_SIGNED   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] operand;
    } job_t;

    localparam int VALUE_W     = 64;
    localparam int BYTE_W      = 8;
    localparam int GROUP_W     = 7;
    localparam int MAX_BYTES   = 10;
    localparam int FIXED_BYTES = 5;
    localparam int CNT_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CONT_BIT = 8'h80;
    localparam logic [7:0] TOP_MASK = 8'h0f;

endpackage

>>> src/leb_front.sv
// ============================================================================
// leb_front - input classifier
// Accepts beats and turns the command into a job kind and a 64-bit operand.
// ============================================================================
module leb_front
(
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,
    input  logic [1:0]          s_axis_tuser,
    input  logic                q_full,
    output logic                push,
    output leb_pkg::job_t       push_job
);

    leb_pkg::cmd_t cmd;

    assign cmd           = leb_pkg::cmd_t'(s_axis_tuser);
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    always_comb
    begin
        push_job.kind    = leb_pkg::KIND_SIGNED;
        push_job.operand = s_axis_tdata;
        case (cmd)
            leb_pkg::CMD_U32_MIN:
            begin
                push_job.kind    = leb_pkg::KIND_UNSIGNED;
                push_job.operand = {32'd0, s_axis_tdata[31:0]};
            end
            leb_pkg::CMD_U32_FIXED:
            begin
                push_job.kind    = leb_pkg::KIND_FIXED;
                push_job.operand = {32'd0, s_axis_tdata[31:0]};
            end
            leb_pkg::CMD_S32:
            begin
                push_job.kind    = leb_pkg::KIND_SIGNED;
                push_job.operand = {{32{s_axis_tdata[31]}}, s_axis_tdata[31:0]};
            end
            default:
            begin
                push_job.kind    = leb_pkg::KIND_SIGNED;
                push_job.operand = s_axis_tdata;
            end
        endcase
    end

endmodule

>>> src/leb_queue.sv
// ============================================================================
// leb_queue - job queue
// Small FIFO of classified jobs between the front and back ends.
// ============================================================================
module leb_queue
#(
    parameter int DEPTH = leb_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  leb_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output leb_pkg::job_t pop_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    leb_pkg::job_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> src/leb_back.sv
// ============================================================================
// leb_back - byte emitter
// Shifts the operand out seven bits per beat into a registered output stage.
// ============================================================================
module leb_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  leb_pkg::job_t       pop_job,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,
    output logic                m_axis_tlast
);

    leb_pkg::job_t               job_reg, job_next;
    logic [leb_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;

    logic        emit;
    logic        done;
    logic        bit6;
    logic        at_cap;
    logic [63:0] rest;
    logic [7:0]  byte_val;

    assign pop  = !busy_reg && !q_empty;
    assign emit = busy_reg && (!out_valid_reg || m_axis_tready);
    assign bit6 = job_reg.operand[6];
    assign at_cap = (cnt_reg == leb_pkg::CNT_W'(leb_pkg::MAX_BYTES - 1));

    always_comb
    begin
        rest     = {7'd0, job_reg.operand[63:7]};
        done     = at_cap;
        byte_val = {1'b0, job_reg.operand[6:0]};
        case (job_reg.kind)
            leb_pkg::KIND_UNSIGNED:
            begin
                done = (rest == '0) || at_cap;
            end
            leb_pkg::KIND_FIXED:
            begin
                done = (cnt_reg == leb_pkg::CNT_W'(leb_pkg::FIXED_BYTES - 1));
                if (done)
                begin
                    byte_val = byte_val & leb_pkg::TOP_MASK;
                end
            end
            default:
            begin
                rest = {{7{job_reg.operand[63]}}, job_reg.operand[63:7]};
                done = ((rest == '0) && !bit6) || ((rest == '1) && bit6) || at_cap;
            end
        endcase
        if (!done)
        begin
            byte_val = byte_val | leb_pkg::CONT_BIT;
        end
    end

    always_comb
    begin
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (pop)
        begin
            job_next  = pop_job;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (emit)
        begin
            job_next.operand = rest;
            cnt_next         = cnt_reg + 1'b1;
            busy_next        = !done;
            out_valid_next   = 1'b1;
            out_byte_next    = byte_val;
            out_last_next    = done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= leb_pkg::CNT_W'(leb_pkg::MAX_BYTES - 1)))
        else $error("byte count past ten");

    a_fixed_len: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && job_reg.kind == leb_pkg::KIND_FIXED) |->
            (done == (cnt_reg == leb_pkg::CNT_W'(leb_pkg::FIXED_BYTES - 1))))
        else $error("fixed form not five bytes");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && done) |=> (!busy_reg && m_axis_tvalid && m_axis_tlast))
        else $error("last beat did not end the job");
`endif

endmodule

>>> src/leb128_encoder_unit.sv
// ============================================================================
// leb128_encoder_unit - LEB128 varint encoder
// Takes a mode and a 64-bit integer, emits its LEB128 bytes, one per beat.
// ============================================================================
//
// Channel   Dir  tdata              tuser       tlast
// s_axis    in   value[63:0]        cmd[1:0]    -
// m_axis    out  out_byte[7:0]      -           last byte of a value
//
// Flow: for a value of 1..10 bytes the back end loads the job from the
// queue, then shifts the bytes out of the operand register one per beat and
// takes the next job only after the last byte has been emitted.
// The front end classifies in the accept cycle and writes a two-entry queue,
// so new values are taken while the back end still emits earlier ones.
// Stalls: m_axis_tready low holds the output register and the emitter;
// s_axis_tready drops only when the queue is full.
// Reset clears the queue pointers, the busy flag and the output valid.
//
module leb128_encoder_unit
#(
    parameter int QUEUE_DEPTH = leb_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last
);

    leb_pkg::job_t push_job;
    leb_pkg::job_t pop_job;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    // Front: accept beat, map command to kind and extend the operand
    leb_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .push_job      (push_job)
    );

    // Queue decouples acceptance from emission
    leb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    // Back: seven bits per beat, stop rule per kind
    leb_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .pop_job       (pop_job),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> tb/leb128_stream_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// leb128_stream_checker - scoreboard for the LEB128 encoder
// Predicts the byte stream for every accepted input beat and compares each
// accepted output beat with the oldest predicted byte.
// ============================================================================
module leb128_stream_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    input  logic        m_axis_tlast,   // last
    output int          fail_count,
    output int          bytes_pending,
    output int          bytes_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    enc_byte_t encoded_bytes[$];
    int        n_fail    = 0;
    int        n_checked = 0;

    // Expands one value into its LEB128 bytes, lowest group first.
    function automatic void predict_encoding(input leb_pkg::cmd_t cmd,
                                             input logic [63:0]   value);
        logic signed [63:0] rest;
        logic [7:0]         grp;
        logic               done;
        int                 n;
        n    = 0;
        done = 1'b0;
        if (cmd == leb_pkg::CMD_U32_FIXED)
        begin
            for (int k = 0; k < leb_pkg::FIXED_BYTES - 1; k++)
            begin
                grp = {1'b0, value[leb_pkg::GROUP_W*k +: leb_pkg::GROUP_W]};
                encoded_bytes.push_back('{data: grp | leb_pkg::CONT_BIT, last: 1'b0});
            end
            grp = {4'b0, value[31:28]} & leb_pkg::TOP_MASK;
            encoded_bytes.push_back('{data: grp, last: 1'b1});
        end
        else
        begin
            case (cmd)
                leb_pkg::CMD_U32_MIN: rest = {32'b0, value[31:0]};
                leb_pkg::CMD_S32:     rest = {{32{value[31]}}, value[31:0]};
                default:              rest = value;
            endcase
            while (!done)
            begin
                grp = {1'b0, rest[6:0]};
                if (cmd == leb_pkg::CMD_U32_MIN)
                begin
                    rest = rest >> leb_pkg::GROUP_W;
                    done = (rest == 64'd0);
                end
                else
                begin
                    rest = rest >>> leb_pkg::GROUP_W;
                    // stop once the sign is carried by bit 6 of this byte
                    done = (rest == 64'd0 && !grp[6]) || (rest == '1 && grp[6]);
                end
                if (n == leb_pkg::MAX_BYTES - 1)
                    done = 1'b1;
                encoded_bytes.push_back('{data: done ? grp : (grp | leb_pkg::CONT_BIT),
                                         last: done});
                n++;
            end
        end
    endfunction

    always @(posedge clk)
    begin
        enc_byte_t want;
        if (rst_n)
        begin
            // outputs first: a beat leaving now belongs to an earlier value
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (encoded_bytes.size() == 0)
                begin
                    n_fail++;
                    $display("%0t ns: stray beat, expected none, actual %02h last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = encoded_bytes.pop_front();
                    n_checked++;
                    if (m_axis_tdata !== want.data)
                    begin
                        n_fail++;
                        $display("%0t ns: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want.data, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        n_fail++;
                        $display("%0t ns: last mismatch, expected %0b, actual %0b",
                                 $time, want.last, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_encoding(leb_pkg::cmd_t'(s_axis_tuser), s_axis_tdata);
        end
        fail_count    <= n_fail;
        bytes_pending <= encoded_bytes.size();
        bytes_checked <= n_checked;
    end

endmodule

>>> tb/tb_leb128_encoder_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_leb128_encoder_unit - testbench top for the LEB128 encoder
// Drives directed and random values in all four modes through the input
// stream under several idle/stall mixes, including one long output hold-off;
// the checker scores every output beat.
// ============================================================================
module tb_leb128_encoder_unit;

    localparam int RAND_ITEMS   = 316;
    localparam int PHASES       = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 24;   // longer than two queued values take to emit

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;    // [63:0] value
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_byte
    logic        m_axis_tlast;          // last

    int fail_count;
    int bytes_pending;
    int bytes_checked;

    // idle rates in percent, changed per phase by the stimulus
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off, requested by the stimulus
    logic hold_go = 1'b0;
    logic rx_hold = 1'b0;

    int values_per_cmd[4];

    leb128_encoder_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    leb128_stream_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending),
        .bytes_checked (bytes_checked)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit: far beyond the slowest legal run (350 values x up to 10 bytes,
    // each byte under receiver stalls, plus the hold-off).
    initial
    begin
        #2000000;
        $display("** leb128_encoder_unit: FAILED **");
        $finish;
    end

    // Receiver: random tready per the current stall rate, forced low while
    // the hold-off runs. Sole driver of m_axis_tready after time zero.
    always @(posedge clk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);

    // Hold-off: keeps the receiver off while the sender offers beats, so the
    // two-entry queue fills and s_axis_tready drops.
    initial
    begin : rx_hold_off
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // One input beat. Random idle cycles come before the beat; tvalid
    // stays high across back-to-back beats.
    task automatic send_value(input leb_pkg::cmd_t cmd, input logic [63:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        values_per_cmd[cmd]++;
    endtask

    // Random value shapes: full width, sign-extended short values (both
    // signs), short positives, and values just around a power of two.
    function automatic logic [63:0] random_value();
        logic [63:0] raw;
        int          sh;
        raw = {$urandom, $urandom};
        sh  = $urandom_range(63);
        case ($urandom_range(3))
            0: return raw;
            1: return $signed(raw) >>> sh;
            2: return raw >> sh;
            default:
            begin
                raw = (64'd1 << sh) - 64'($urandom_range(1));
                return $urandom_range(1) ? -raw : raw;
            end
        endcase
    endfunction

    initial
    begin : stimulus
        leb_pkg::cmd_t cmd;
        int            waited;
        logic [63:0]   directed_vals[$];

        for (int c = 0; c < 4; c++)
            values_per_cmd[c] = 0;

        // hold reset, then release it on a clock edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: group boundaries, sign-bit-6 cases, 32-bit extremes,
        // garbage in the upper half for 32-bit modes, 64-bit extremes.
        directed_vals = '{64'd0, 64'd1, 64'h3f, 64'h40, 64'h7f, 64'h80,
                          64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffc0,
                          64'hffff_ffff_ffff_ffbf, 64'h0000_0000_7fff_ffff,
                          64'h0000_0000_8000_0000, 64'h0000_0000_ffff_ffff,
                          64'hdead_beef_0000_0005, 64'h7fff_ffff_ffff_ffff,
                          64'h8000_0000_0000_0000, 64'h0123_4567_89ab_cdef};
        // every mode on the first six, then rotate modes over the rest
        for (int i = 0; i < 6; i++)
            for (int c = 0; c < 4; c++)
                send_value(leb_pkg::cmd_t'(c), directed_vals[i]);
        for (int i = 6; i < directed_vals.size(); i++)
            send_value(leb_pkg::cmd_t'(i % 4), directed_vals[i]);

        // Random phases: none / sender idle / receiver stall / both
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 52;
                end
                default:
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 37;
                end
            endcase
            // back pressure while the sender keeps offering beats
            if (p == 0)
                hold_go = 1'b1;
            for (int i = 0; i < RAND_ITEMS / PHASES; i++)
            begin
                cmd = leb_pkg::cmd_t'($urandom_range(3));
                send_value(cmd, random_value());
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain with the receiver always ready
        recv_idle_pct = 0;
        waited = 0;
        while (bytes_pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (bytes_pending != 0)
        begin
            $display("** leb128_encoder_unit: FAILED **");
            $finish;
        end
        else
        begin
            // extra cycles to catch any stray beats
            repeat (TAIL_CYCLES) @(posedge clk);
            $display("Encoded %0d values (u32 min %0d, u32 fixed %0d, s32 %0d, s64 %0d),",
                     values_per_cmd[0] + values_per_cmd[1] + values_per_cmd[2]
                     + values_per_cmd[3], values_per_cmd[0], values_per_cmd[1],
                     values_per_cmd[2], values_per_cmd[3]);
            $display("%0d output bytes scored across four idle mixes and a %0d-cycle hold-off.",
                     bytes_checked, HOLD_CYCLES);
            if (fail_count == 0 && bytes_pending == 0)
                $display("** leb128_encoder_unit: PASSED **");
            else
                $display("** leb128_encoder_unit: FAILED **");
            $finish;
        end
    end

endmodule
